/* sv/volume_block_address_mapper_core_defines.svh */
// Assertion helpers used by the checker file.
`ifndef VOLUME_BLOCK_ADDRESS_MAPPER_CORE_DEFINES_SVH
`define VOLUME_BLOCK_ADDRESS_MAPPER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VBAM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VBAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/vbam_pkg.sv */
package vbam_pkg;

    localparam int unsigned MAX_MEMBERS = 4;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned UNIT_W      = 26;   // 2^32 / 100 fits in 26 bits

    // x / 100 == (x * RECIP100) >> 38 for every 32-bit x
    localparam logic [63:0] RECIP100  = 64'd2748779070;
    localparam int unsigned SHIFT100  = 38;
    // x / 3 == (x * RECIP3) >> 33 for every 32-bit x
    localparam logic [63:0] RECIP3    = 64'h0000_0000_AAAA_AAAB;
    localparam int unsigned SHIFT3    = 33;
    localparam logic [6:0]  PCT_SCALE = 7'd100;

    typedef enum logic [1:0] {
        MODE_CONCAT = 2'd0,
        MODE_STRIPE = 2'd1,
        MODE_PART   = 2'd2,
        MODE_RSVD   = 2'd3
    } mode_t;

    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_COUNT = 3'd1;
    localparam logic [2:0] REG_START = 3'd2;
    localparam logic [2:0] REG_LEN   = 3'd3;
    localparam logic [2:0] REG_SIZE0 = 3'd4;
    localparam logic [2:0] REG_SIZE1 = 3'd5;
    localparam logic [2:0] REG_SIZE2 = 3'd6;
    localparam logic [2:0] REG_SIZE3 = 3'd7;

    typedef struct packed {
        mode_t                            mode;
        logic [CNT_W-1:0]                 member_count;
        logic [6:0]                       part_start_pct;
        logic [6:0]                       part_len_pct;
        logic [MAX_MEMBERS-1:0][31:0]     member_size;
    } cfg_t;

    // after stage 1: reciprocal products and first partial sums
    typedef struct packed {
        logic [31:0]       block;
        logic [CNT_W-1:0]  n;
        logic [UNIT_W-1:0] unit;
        logic [30:0]       q3;
        logic [31:0]       e1;
        logic [31:0]       p23;
    } s1_t;

    // after stage 2: partition bounds, stripe remainder, concat ends of members 1 to 3
    typedef struct packed {
        logic [31:0]       block;
        logic [CNT_W-1:0]  n;
        logic [31:0]       base;
        logic [31:0]       size_raw;
        logic [31:0]       full;
        logic [30:0]       q3;
        logic [1:0]        r3;
        logic [31:0]       e1;
        logic [31:0]       e2;
        logic [31:0]       e3;
    } s2_t;

    typedef struct packed {
        logic [1:0]  member_slot;
        logic [31:0] member_offset;
        logic        miss;
    } res_t;

    // member count clamped to 1..MAX_MEMBERS
    function automatic logic [CNT_W-1:0] used_members(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] n;
        n = cnt;
        if (n == '0)
            n = CNT_W'(1);
        if (n > CNT_W'(MAX_MEMBERS))
            n = CNT_W'(MAX_MEMBERS);
        return n;
    endfunction

endpackage

/* sv/vbam_if.sv */
interface vbam_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] logical_block;

    modport source (output valid, output logical_block, input ready);
    modport sink   (input valid, input logical_block, output ready);
endinterface

interface vbam_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  member_slot;
    logic [31:0] member_offset;
    logic        miss;

    modport source (output valid, output member_slot, output member_offset, output miss,
                    input ready);
    modport sink   (input valid, input member_slot, input member_offset, input miss,
                    output ready);
endinterface

/* sv/vbam_cfg.sv */
module vbam_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output vbam_pkg::cfg_t     cfg
);

    vbam_pkg::cfg_t cfg_reg;
    vbam_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                vbam_pkg::REG_MODE:  cfg_next.mode = vbam_pkg::mode_t'(cfg_data[1:0]);
                vbam_pkg::REG_COUNT: cfg_next.member_count = cfg_data[vbam_pkg::CNT_W-1:0];
                vbam_pkg::REG_START: cfg_next.part_start_pct = cfg_data[6:0];
                vbam_pkg::REG_LEN:   cfg_next.part_len_pct = cfg_data[6:0];
                vbam_pkg::REG_SIZE0: cfg_next.member_size[0] = cfg_data;
                vbam_pkg::REG_SIZE1: cfg_next.member_size[1] = cfg_data;
                vbam_pkg::REG_SIZE2: cfg_next.member_size[2] = cfg_data;
                vbam_pkg::REG_SIZE3: cfg_next.member_size[3] = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{mode:         vbam_pkg::MODE_CONCAT,
                         member_count: vbam_pkg::CNT_W'(1),
                         default:      '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/vbam_stage1.sv */
module vbam_stage1 (
    input  logic               clk,
    input  logic               rst_n,
    input  vbam_pkg::cfg_t     cfg,
    input  logic               up_valid,
    output logic               up_ready,
    input  logic [31:0]        up_block,
    output logic               dn_valid,
    input  logic               dn_ready,
    output vbam_pkg::s1_t      dn_data
);

    logic          valid_reg;
    vbam_pkg::s1_t data_reg;
    vbam_pkg::s1_t data_next;
    logic [63:0]   unit_prod;
    logic [63:0]   q3_prod;
    logic          load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        unit_prod       = 64'(cfg.member_size[0]) * vbam_pkg::RECIP100;
        q3_prod         = 64'(up_block) * vbam_pkg::RECIP3;
        data_next.block = up_block;
        data_next.n     = vbam_pkg::used_members(cfg.member_count);
        data_next.unit  = unit_prod[vbam_pkg::SHIFT100 +: vbam_pkg::UNIT_W];
        data_next.q3    = q3_prod[vbam_pkg::SHIFT3 +: 31];
        data_next.e1    = cfg.member_size[0] + cfg.member_size[1];
        data_next.p23   = cfg.member_size[2] + cfg.member_size[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

/* sv/vbam_stage2.sv */
module vbam_stage2 (
    input  logic               clk,
    input  logic               rst_n,
    input  vbam_pkg::cfg_t     cfg,
    input  logic               up_valid,
    output logic               up_ready,
    input  vbam_pkg::s1_t      up_data,
    output logic               dn_valid,
    input  logic               dn_ready,
    output vbam_pkg::s2_t      dn_data
);

    logic          valid_reg;
    vbam_pkg::s2_t data_reg;
    vbam_pkg::s2_t data_next;
    logic [32:0]   base_prod;
    logic [32:0]   size_prod;
    logic [32:0]   full_prod;
    logic [31:0]   three_q;
    logic [31:0]   rem;
    logic          load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        base_prod = 33'(up_data.unit) * 33'(cfg.part_start_pct);
        size_prod = 33'(up_data.unit) * 33'(cfg.part_len_pct);
        full_prod = 33'(up_data.unit) * 33'(vbam_pkg::PCT_SCALE);
        three_q   = 32'({up_data.q3, 1'b0}) + 32'(up_data.q3);
        rem       = up_data.block - three_q;

        data_next.block    = up_data.block;
        data_next.n        = up_data.n;
        data_next.base     = base_prod[31:0];
        data_next.size_raw = size_prod[31:0];
        data_next.full     = full_prod[31:0];
        data_next.q3       = up_data.q3;
        data_next.r3       = rem[1:0];
        data_next.e1       = up_data.e1;
        data_next.e2       = up_data.e1 + cfg.member_size[2];
        data_next.e3       = up_data.e1 + up_data.p23;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

/* sv/vbam_stage3.sv */
module vbam_stage3 (
    input  logic               clk,
    input  logic               rst_n,
    input  vbam_pkg::cfg_t     cfg,
    input  logic               up_valid,
    output logic               up_ready,
    input  vbam_pkg::s2_t      up_data,
    output logic               dn_valid,
    input  logic               dn_ready,
    output vbam_pkg::res_t     dn_data
);

    logic                                    valid_reg;
    vbam_pkg::res_t                          res_reg;
    vbam_pkg::res_t                          res_next;
    logic [vbam_pkg::MAX_MEMBERS-1:0][31:0]  ends;
    logic [vbam_pkg::MAX_MEMBERS-1:0][31:0]  starts;
    logic [vbam_pkg::MAX_MEMBERS-1:0]        hit;
    logic [31:0]                             part_size;
    logic                                    load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        ends[0]   = cfg.member_size[0];
        ends[1]   = up_data.e1;
        ends[2]   = up_data.e2;
        ends[3]   = up_data.e3;
        starts[0] = '0;
        starts[1] = cfg.member_size[0];
        starts[2] = up_data.e1;
        starts[3] = up_data.e2;
        for (int i = 0; i < vbam_pkg::MAX_MEMBERS; i++)
            hit[i] = (vbam_pkg::CNT_W'(i) < up_data.n) && (up_data.block < ends[i]);

        part_size = (up_data.size_raw == '0) ? up_data.full : up_data.size_raw;

        res_next.member_slot   = '0;
        res_next.member_offset = '0;
        res_next.miss          = 1'b1;

        unique case (cfg.mode)
            vbam_pkg::MODE_CONCAT:
            begin
                // lowest slot whose end lies past the block wins
                for (int i = vbam_pkg::MAX_MEMBERS - 1; i >= 0; i--)
                begin
                    if (hit[i])
                    begin
                        res_next.member_slot   = 2'(i);
                        res_next.member_offset = up_data.block - starts[i];
                        res_next.miss          = 1'b0;
                    end
                end
            end
            vbam_pkg::MODE_STRIPE:
            begin
                res_next.miss = 1'b0;
                unique case (up_data.n)
                    3'd2:
                    begin
                        res_next.member_slot   = {1'b0, up_data.block[0]};
                        res_next.member_offset = {1'b0, up_data.block[31:1]};
                    end
                    3'd3:
                    begin
                        res_next.member_slot   = up_data.r3;
                        res_next.member_offset = {1'b0, up_data.q3};
                    end
                    3'd4:
                    begin
                        res_next.member_slot   = up_data.block[1:0];
                        res_next.member_offset = {2'b00, up_data.block[31:2]};
                    end
                    default:
                    begin
                        res_next.member_slot   = '0;
                        res_next.member_offset = up_data.block;
                    end
                endcase
            end
            vbam_pkg::MODE_PART:
            begin
                if (up_data.block < part_size)
                begin
                    res_next.member_offset = up_data.base + up_data.block;
                    res_next.miss          = 1'b0;
                end
            end
            vbam_pkg::MODE_RSVD:
            begin
                res_next.miss = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = res_reg;

endmodule

/* sv/volume_block_address_mapper_core.sv */
// A request accepted into stage 1 passes through the stage 2 and stage 3 registers before its result shows.
// Throughput: one request per cycle, sustained, as long as map_out is taken.
// Each of the three stages holds its own request and stalls only when full and
// the next stage is blocked, so bubbles collapse under back-pressure.
// Reset: pipeline valid bits clear; mode 0, member_count 1, all other registers 0.
module volume_block_address_mapper_core (
    input  logic         clk,
    input  logic         rst_n,
    vbam_in_if.sink      blk_in,
    vbam_out_if.source   map_out,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    // The user must make configuration changes only while no request is in flight;
    // the block does not enforce it, and every stage reads the live register set directly.
    vbam_pkg::cfg_t  cfg;

    logic            s1_valid;
    logic            s1_ready;
    vbam_pkg::s1_t   s1_data;
    logic            s2_valid;
    logic            s2_ready;
    vbam_pkg::s2_t   s2_data;
    logic            s3_valid;
    vbam_pkg::res_t  s3_data;

    vbam_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage 1: reciprocal multiplies (member 0 / 100, block / 3) and the
    // first layer of the member-size prefix sums.
    vbam_stage1 u_stage1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (blk_in.valid),
        .up_ready (blk_in.ready),
        .up_block (blk_in.logical_block),
        .dn_valid (s1_valid),
        .dn_ready (s1_ready),
        .dn_data  (s1_data)
    );

    // Stage 2: partition base / length / whole-device size from the unit,
    // the mod-3 remainder, and the remaining prefix sums.
    vbam_stage2 u_stage2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .dn_data  (s2_data)
    );

    // Stage 3: bounds compares, offset subtract/add, mode select; this is
    // also the output register.
    vbam_stage3 u_stage3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (s2_valid),
        .up_ready (s2_ready),
        .up_data  (s2_data),
        .dn_valid (s3_valid),
        .dn_ready (map_out.ready),
        .dn_data  (s3_data)
    );

    assign map_out.valid         = s3_valid;
    assign map_out.member_slot   = s3_data.member_slot;
    assign map_out.member_offset = s3_data.member_offset;
    assign map_out.miss          = s3_data.miss;

endmodule

/* sv/vbam_chk.sv */
`include "volume_block_address_mapper_core_defines.svh"

module vbam_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  out_slot,
    input  logic [31:0] out_offset,
    input  logic        out_miss
);

    // stalled result holds
    `VBAM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_slot) && $stable(out_offset) && $stable(out_miss), "result changed while stalled")

    // a draining output leaves room at the input
    `VBAM_ASSERT_NOW(a_ready_flow, out_ready, in_ready, "input blocked while output drains")

    // a miss carries a zero address
    `VBAM_ASSERT_NOW(a_miss_zero, out_valid && out_miss, out_slot == 2'd0 && out_offset == 32'd0, "miss with nonzero address")

    // an empty output register lets every stage move up
    `VBAM_ASSERT_NOW(a_empty_ready, !out_valid, in_ready, "input blocked with output empty")

endmodule

bind volume_block_address_mapper_core vbam_chk u_vbam_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (blk_in.valid),
    .in_ready   (blk_in.ready),
    .out_valid  (map_out.valid),
    .out_ready  (map_out.ready),
    .out_slot   (map_out.member_slot),
    .out_offset (map_out.member_offset),
    .out_miss   (map_out.miss)
);

/* tb/sv/volume_block_address_mapper_core_test.sv */
module volume_block_address_mapper_core_test;

    // No-progress limit. The longest correct quiet stretch is the forced
    // receiver hold-off, so this leaves a wide margin.
    localparam int unsigned IDLE_LIMIT   = 20000;
    // Cycles to wait after the last result before touching config or ending.
    // The margin after the last expected result catches stray results.
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned RANDOM_REQUESTS = 1150;
    localparam int unsigned HOLD_OFF_CYCLES = 200;

    typedef struct {
        logic [31:0]    block;
        vbam_pkg::res_t map;
    } pending_map_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    vbam_in_if  blk_in();
    vbam_out_if map_out();

    volume_block_address_mapper_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_in    (blk_in),
        .map_out   (map_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the config registers, updated as each write is issued.
    vbam_pkg::mode_t cur_mode;
    logic [2:0]      cur_count;
    logic [6:0]      cur_start_pct;
    logic [6:0]      cur_len_pct;
    logic [31:0]     cur_size [vbam_pkg::MAX_MEMBERS];

    // Expected mappings, oldest first, pushed when a request is accepted.
    pending_map_t pending_maps [$];

    int  error_count;
    int  idle_cycles;
    int  burst_left;      // requests left in the current sender burst
    int  hold_left;       // forced receiver hold-off, counted down by the receiver
    int  sink_run;        // cycles left at the current receiver level
    bit  sink_level;
    bit  source_steady;   // sender never inserts gaps
    bit  sink_steady;     // receiver ready except during a forced hold-off
    bit  request_sent;    // something went in since the last drain

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: computes the expected mapping from the shadow config.
    // ------------------------------------------------------------------
    function automatic vbam_pkg::res_t map_block(input logic [31:0] blk);
        vbam_pkg::res_t r;
        logic [2:0]     n;
        logic [31:0]    total;
        logic [31:0]    span_end;
        logic [31:0]    unit;
        logic [31:0]    base;
        logic [31:0]    span;
        bit             hit;

        // count of zero behaves as one, anything above the max saturates
        n = cur_count;
        if (n == 3'd0)
            n = 3'd1;
        if (n > 3'(vbam_pkg::MAX_MEMBERS))
            n = 3'(vbam_pkg::MAX_MEMBERS);

        r.member_slot   = 2'd0;
        r.member_offset = 32'd0;
        r.miss          = 1'b1;

        case (cur_mode)
            vbam_pkg::MODE_CONCAT:
            begin
                // running total wraps at 32 bits; the hit test uses the wrapped end
                total = 32'd0;
                hit   = 1'b0;
                for (int i = 0; i < vbam_pkg::MAX_MEMBERS; i++)
                begin
                    if (!hit && i < n)
                    begin
                        span_end = total + cur_size[i];
                        if (blk < span_end)
                        begin
                            r.member_slot   = 2'(i);
                            r.member_offset = blk - total;
                            r.miss          = 1'b0;
                            hit             = 1'b1;
                        end
                        total = span_end;
                    end
                end
            end
            vbam_pkg::MODE_STRIPE:
            begin
                // no bounds check in interleave
                r.member_slot   = 2'(blk % 32'(n));
                r.member_offset = blk / 32'(n);
                r.miss          = 1'b0;
            end
            vbam_pkg::MODE_PART:
            begin
                // hundredths of member 0; products and the offset wrap at 32 bits
                unit = cur_size[0] / 32'd100;
                base = 32'(cur_start_pct) * unit;
                span = 32'(cur_len_pct) * unit;
                if (span == 32'd0)
                    span = unit * 32'd100;
                if (blk < span)
                begin
                    r.member_offset = base + blk;
                    r.miss          = 1'b0;
                end
            end
            default:
            begin
                // reserved mode: everything misses
            end
        endcase

        if (r.miss)
        begin
            r.member_slot   = 2'd0;
            r.member_offset = 32'd0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting: one line per mismatch, all counted.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] blk,
                                   input logic [31:0] got, input logic [31:0] want);
        $display("mismatch: %s block=%h got=%h want=%h", what, blk, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Request side. Called at a falling edge, returns at a falling edge with
    // valid still high so back-to-back requests never drop it.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [31:0] blk);
        int           gap;
        pending_map_t entry;

        if (burst_left == 0)
        begin
            gap = source_steady ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                blk_in.valid = 1'b0;
                blk_in.logical_block = $urandom;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;

        blk_in.valid         = 1'b1;
        blk_in.logical_block = blk;
        @(posedge clk);
        while (!blk_in.ready)
            @(posedge clk);

        // config is stable while requests are in flight, so predict now
        entry.block = blk;
        entry.map   = map_block(blk);
        pending_maps.push_back(entry);
        request_sent = 1'b1;
        @(negedge clk);
    endtask

    // Stop sending, wait for every expected result, then let the pipe settle.
    task automatic drain_pipeline();
        blk_in.valid = 1'b0;
        if (request_sent)
        begin
            while (pending_maps.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
            request_sent = 1'b0;
        end
    endtask

    // Register write; always made with the pipeline empty.
    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        drain_pipeline();
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (index)
            vbam_pkg::REG_MODE:  cur_mode      = vbam_pkg::mode_t'(value[1:0]);
            vbam_pkg::REG_COUNT: cur_count     = value[2:0];
            vbam_pkg::REG_START: cur_start_pct = value[6:0];
            vbam_pkg::REG_LEN:   cur_len_pct   = value[6:0];
            vbam_pkg::REG_SIZE0, vbam_pkg::REG_SIZE1,
            vbam_pkg::REG_SIZE2, vbam_pkg::REG_SIZE3:
                cur_size[index - vbam_pkg::REG_SIZE0] = value;
            default: ;
        endcase
    endtask

    task automatic config_all(input vbam_pkg::mode_t m, input logic [2:0] count,
                              input logic [6:0] start_pct, input logic [6:0] len_pct,
                              input logic [31:0] s0, input logic [31:0] s1,
                              input logic [31:0] s2, input logic [31:0] s3);
        write_reg(vbam_pkg::REG_MODE,  32'(m));
        write_reg(vbam_pkg::REG_COUNT, 32'(count));
        write_reg(vbam_pkg::REG_START, 32'(start_pct));
        write_reg(vbam_pkg::REG_LEN,   32'(len_pct));
        write_reg(vbam_pkg::REG_SIZE0, s0);
        write_reg(vbam_pkg::REG_SIZE1, s1);
        write_reg(vbam_pkg::REG_SIZE2, s2);
        write_reg(vbam_pkg::REG_SIZE3, s3);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern of runs at random levels, plus the forced
    // hold-off that the backpressure test asks for.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            map_out.ready = 1'b0;
            hold_left--;
        end
        else if (sink_steady)
            map_out.ready = 1'b1;
        else
        begin
            if (sink_run == 0)
            begin
                sink_level = ($urandom_range(0, 3) != 0);
                sink_run   = $urandom_range(1, 10);
            end
            sink_run--;
            map_out.ready = sink_level;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        pending_map_t want;
        if (rst_n && map_out.valid && map_out.ready)
        begin
            if (pending_maps.size() == 0)
                report_mismatch("result with no request pending", 32'hx,
                                map_out.member_offset, 32'hx);
            else
            begin
                want = pending_maps.pop_front();
                if (map_out.member_slot !== want.map.member_slot)
                    report_mismatch("member_slot", want.block,
                                    32'(map_out.member_slot), 32'(want.map.member_slot));
                if (map_out.member_offset !== want.map.member_offset)
                    report_mismatch("member_offset", want.block,
                                    map_out.member_offset, want.map.member_offset);
                if (map_out.miss !== want.map.miss)
                    report_mismatch("miss", want.block,
                                    32'(map_out.miss), 32'(want.map.miss));
            end
        end
    end

    // Watchdog: any handshake or register write counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (blk_in.valid && blk_in.ready) ||
            (map_out.valid && map_out.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers at reset: concatenation of one member of size 0, so all miss.
    task automatic test_reset_state();
        send_request(32'd0);
        send_request(32'hFFFF_FFFF);
    endtask

    task automatic test_concat();
        // ends at 10, 30, 30 (empty slot 2), 78
        config_all(vbam_pkg::MODE_CONCAT, 3'd4, 7'd0, 7'd0,
                   32'd10, 32'd20, 32'd0, 32'd48);
        send_request(32'd0);
        send_request(32'd9);
        send_request(32'd10);
        send_request(32'd30);    // skips the empty slot
        send_request(32'd77);
        send_request(32'd78);    // one past the end
        // count above max saturates; running total wraps after slot 0
        config_all(vbam_pkg::MODE_CONCAT, 3'd7, 7'd0, 7'd0,
                   32'hFFFF_FFF0, 32'h20, 32'h5, 32'h5);
        send_request(32'hFFFF_FFF0);
        send_request(32'hFFFF_FFFF);
        // count of zero acts as one
        write_reg(vbam_pkg::REG_COUNT, 32'd0);
        send_request(32'hFFFF_FFEF);
        send_request(32'hFFFF_FFF0);
    endtask

    task automatic test_stripe();
        config_all(vbam_pkg::MODE_STRIPE, 3'd3, 7'd0, 7'd0,
                   32'd0, 32'd0, 32'd0, 32'd0);
        send_request(32'hFFFF_FFFF);
        send_request(32'd7);
        write_reg(vbam_pkg::REG_COUNT, 32'd7);
        send_request(32'hFFFF_FFFF);
        write_reg(vbam_pkg::REG_COUNT, 32'd0);
        send_request(32'd123);
    endtask

    task automatic test_partition();
        // full-size member, start at 100%, length 0 means whole device
        config_all(vbam_pkg::MODE_PART, 3'd1, 7'd100, 7'd0,
                   32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
        send_request(32'd0);
        send_request(32'hFFFF_FF9F);    // last block in range, offset wraps
        send_request(32'hFFFF_FFA0);    // first block out of range
        // percentages past 100, products wrap
        write_reg(vbam_pkg::REG_START, 32'd127);
        write_reg(vbam_pkg::REG_LEN, 32'd127);
        send_request(32'd0);
        send_request(32'hFFFF_FFFF);
        // member 0 under 100 blocks: unit is 0, nothing fits
        write_reg(vbam_pkg::REG_SIZE0, 32'd99);
        send_request(32'd0);
    endtask

    task automatic test_reserved_mode();
        write_reg(vbam_pkg::REG_MODE, 32'(vbam_pkg::MODE_RSVD));
        send_request(32'd0);
        send_request(32'h0000_1234);
    endtask

    // Receiver holds off for a long stretch while the sender keeps pushing,
    // so the pipe fills and input ready must drop.
    task automatic test_backpressure();
        config_all(vbam_pkg::MODE_STRIPE, 3'd2, 7'd0, 7'd0,
                   32'd0, 32'd0, 32'd0, 32'd0);
        source_steady = 1'b1;
        sink_steady   = 1'b1;
        hold_left     = HOLD_OFF_CYCLES;
        repeat (40) send_request($urandom);
        drain_pipeline();
        source_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    // Random config per phase, about half the requests aimed at range boundaries.
    task automatic test_random();
        int              sent;
        int              phase_len;
        int              pick;
        int              k;
        vbam_pkg::mode_t m;
        logic [6:0]      pct [2];
        logic [31:0]     sz [vbam_pkg::MAX_MEMBERS];
        logic [31:0]     anchor;
        logic [31:0]     unit;

        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            pick = $urandom_range(0, 9);
            m = (pick < 3) ? vbam_pkg::MODE_CONCAT :
                (pick < 6) ? vbam_pkg::MODE_STRIPE :
                (pick < 9) ? vbam_pkg::MODE_PART : vbam_pkg::MODE_RSVD;
            for (int j = 0; j < 2; j++)
            begin
                case ($urandom_range(0, 4))
                    0:       pct[j] = 7'd0;
                    1:       pct[j] = 7'd100;
                    2:       pct[j] = 7'd127;
                    default: pct[j] = 7'($urandom_range(0, 127));
                endcase
            end
            for (int j = 0; j < vbam_pkg::MAX_MEMBERS; j++)
            begin
                case ($urandom_range(0, 5))
                    0:       sz[j] = 32'd0;
                    1:       sz[j] = 32'hFFFF_FFFF;
                    2:       sz[j] = $urandom_range(1, 300);
                    3:       sz[j] = $urandom_range(100, 10000);
                    default: sz[j] = $urandom;
                endcase
            end
            config_all(m, 3'($urandom_range(0, 7)), pct[0], pct[1],
                       sz[0], sz[1], sz[2], sz[3]);

            source_steady = ($urandom_range(0, 3) == 0);
            sink_steady   = ($urandom_range(0, 3) == 0);
            phase_len     = $urandom_range(30, 70);

            repeat (phase_len)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                begin
                    // near a boundary: a concat end or the partition limit
                    if (cur_mode == vbam_pkg::MODE_PART)
                    begin
                        unit   = cur_size[0] / 32'd100;
                        anchor = 32'(cur_len_pct) * unit;
                        if (anchor == 32'd0)
                            anchor = unit * 32'd100;
                    end
                    else
                    begin
                        k      = $urandom_range(0, vbam_pkg::MAX_MEMBERS - 1);
                        anchor = 32'd0;
                        for (int j = 0; j <= k; j++)
                            anchor = anchor + cur_size[j];
                    end
                    send_request(anchor + 32'($urandom_range(0, 4)) - 32'd2);
                end
                else if (pick == 5)
                    send_request($urandom_range(0, 255));
                else
                    send_request($urandom);
                sent++;
            end
        end
        source_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = vbam_pkg::REG_MODE;
        cfg_data             = 32'd0;
        blk_in.valid         = 1'b0;
        blk_in.logical_block = 32'd0;
        map_out.ready        = 1'b0;

        cur_mode      = vbam_pkg::MODE_CONCAT;
        cur_count     = 3'd1;
        cur_start_pct = 7'd0;
        cur_len_pct   = 7'd0;
        for (int j = 0; j < vbam_pkg::MAX_MEMBERS; j++)
            cur_size[j] = 32'd0;

        error_count   = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        hold_left     = 0;
        sink_run      = 0;
        sink_level    = 1'b1;
        source_steady = 1'b0;
        sink_steady   = 1'b0;
        request_sent  = 1'b0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_concat();
        test_stripe();
        test_partition();
        test_reserved_mode();
        test_backpressure();
        test_random();
        drain_pipeline();

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
